[src/hdhc_pkg.sv]
package hdhc_pkg;

    localparam int TEMP_W    = 12;
    localparam int VBAT_W    = 13;
    localparam int HYST_W    = 6;
    localparam int COUNT_W   = 8;
    localparam int DUTY_W    = 10;
    localparam int CMP_W     = 14;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    localparam logic [DUTY_W-1:0] DUTY_OFF       = 10'd0;
    localparam logic [DUTY_W-1:0] DUTY_KEEP_WARM = 10'd300;
    localparam logic [DUTY_W-1:0] DUTY_WARM_UP   = 10'd600;
    localparam logic [DUTY_W-1:0] DUTY_COLD_HIGH = 10'd1000;
    localparam logic [DUTY_W-1:0] DUTY_COLD_LOW  = 10'd500;
    localparam logic [DUTY_W-1:0] DUTY_PREWARM   = 10'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VBAT_CUT    = 3'd0,
        REG_VBAT_RESUME = 3'd1,
        REG_VBAT_RICH   = 3'd2,
        REG_TEMP_OFF    = 3'd3,
        REG_TEMP_WARM   = 3'd4,
        REG_TEMP_COLD   = 3'd5,
        REG_TEMP_HYST   = 3'd6,
        REG_PREWARM     = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_tenths;
        logic                     temp_valid;
        logic [VBAT_W-1:0]        vbat_mv;
        logic                     ranging_active;
    } item_t;

    typedef struct packed {
        logic [VBAT_W-1:0]        vbat_cut_mv;
        logic [VBAT_W-1:0]        vbat_resume_mv;
        logic [VBAT_W-1:0]        vbat_rich_mv;
        logic signed [TEMP_W-1:0] temp_off_c10;
        logic signed [TEMP_W-1:0] temp_warm_c10;
        logic signed [TEMP_W-1:0] temp_cold_c10;
        logic [HYST_W-1:0]        temp_hyst_c10;
        logic [COUNT_W-1:0]       prewarm_seconds;
    } cfg_t;

    typedef struct packed {
        logic                cut_latch;
        logic [COUNT_W-1:0]  prewarm_left;
        logic [DUTY_W-1:0]   last_level;
    } state_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_permille;
        logic              voltage_cut;
        logic              prewarming;
    } result_t;

    localparam cfg_t CFG_RESET = '{
        vbat_cut_mv:     13'd3150,
        vbat_resume_mv:  13'd3300,
        vbat_rich_mv:    13'd3600,
        temp_off_c10:    12'sd150,
        temp_warm_c10:   12'sd0,
        temp_cold_c10:   -12'sd50,
        temp_hyst_c10:   6'd5,
        prewarm_seconds: 8'd10
    };

endpackage

[src/hdhc_core.sv]
module hdhc_core (
    input  hdhc_pkg::item_t   item,
    input  hdhc_pkg::cfg_t    cfg,
    input  hdhc_pkg::state_t  state,
    output hdhc_pkg::result_t result,
    output hdhc_pkg::state_t  state_next
);
    import hdhc_pkg::*;

    logic signed [CMP_W-1:0] t_x;
    logic signed [CMP_W-1:0] h_x;
    logic signed [CMP_W-1:0] off_x;
    logic signed [CMP_W-1:0] warm_x;
    logic signed [CMP_W-1:0] cold_x;
    logic                    cut_now;
    logic                    cold_low;
    logic                    hold_off;
    logic                    hold_warm;
    logic                    hold_cold;
    logic [DUTY_W-1:0]       band_duty;

    assign t_x    = CMP_W'(item.temp_tenths);
    assign h_x    = $signed({{(CMP_W-HYST_W){1'b0}}, cfg.temp_hyst_c10});
    assign off_x  = CMP_W'(cfg.temp_off_c10);
    assign warm_x = CMP_W'(cfg.temp_warm_c10);
    assign cold_x = CMP_W'(cfg.temp_cold_c10);

    assign cut_now = (item.vbat_mv < cfg.vbat_cut_mv) ? 1'b1 :
                     (item.vbat_mv >= cfg.vbat_resume_mv) ? 1'b0 : state.cut_latch;

    assign cold_low = (item.temp_tenths < cfg.temp_cold_c10)
                   && (item.vbat_mv < cfg.vbat_rich_mv);

    assign hold_cold = (state.last_level == DUTY_COLD_HIGH)
                    || (state.last_level == DUTY_COLD_LOW)
                    || (state.last_level == DUTY_PREWARM);
    assign hold_warm = hold_cold || (state.last_level == DUTY_WARM_UP);
    assign hold_off  = hold_warm || (state.last_level == DUTY_KEEP_WARM);

    always_comb
    begin
        if (t_x >= off_x + h_x)
            band_duty = DUTY_OFF;
        else if (t_x >= off_x - h_x)
            band_duty = hold_off ? state.last_level : DUTY_KEEP_WARM;
        else if (t_x >= warm_x + h_x)
            band_duty = DUTY_KEEP_WARM;
        else if (t_x >= warm_x - h_x)
            band_duty = hold_warm ? state.last_level : DUTY_WARM_UP;
        else if (t_x >= cold_x + h_x)
            band_duty = DUTY_WARM_UP;
        else if (t_x >= cold_x - h_x)
            band_duty = hold_cold ? state.last_level : DUTY_COLD_LOW;
        else
            band_duty = (item.vbat_mv >= cfg.vbat_rich_mv) ? DUTY_COLD_HIGH : DUTY_COLD_LOW;
    end

    always_comb
    begin
        result     = '0;
        state_next = state;
        if (!item.temp_valid)
        begin
            state_next = '0;
        end
        else if (cut_now)
        begin
            state_next.cut_latch = 1'b1;
            result.voltage_cut   = 1'b1;
        end
        else if (item.ranging_active)
        begin
            state_next.cut_latch = 1'b0;
            result.duty_permille = DUTY_PREWARM;
        end
        else if (cold_low && (state.prewarm_left != '0))
        begin
            state_next.cut_latch    = 1'b0;
            state_next.prewarm_left = state.prewarm_left - COUNT_W'(1);
            result.duty_permille    = DUTY_PREWARM;
            result.prewarming       = 1'b1;
        end
        else
        begin
            state_next.cut_latch = 1'b0;
            if (cold_low && (state.prewarm_left == '0) && (state.last_level == '0))
                state_next.prewarm_left = cfg.prewarm_seconds;
            state_next.last_level = band_duty;
            result.duty_permille  = band_duty;
        end
    end

endmodule

[src/heater_duty_hysteresis_controller.sv]
// channel | direction | handshake         | payload
// s_      | in        | s_tvalid/s_tready | s_tdata, s_tuser: one control tick
// m_      | out       | m_tvalid/m_tready | m_tdata: duty and status of that tick
// cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data: register write
//
// one tick per clock while the output is not stalled; a tick enters the input register,
// and its result is then registered in the output register, which drives m_tvalid
// the state (cut latch, prewarm countdown, last level) updates as a tick moves
// from the input register to the output register
// reset clears the state and loads the default register values
// while m_tvalid is high and m_tready low the output register holds; s_tready stays
// high unless both registers are full and m_tready is low
module heater_duty_hysteresis_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // temp_tenths [11:0], vbat_mv [24:12], ranging_active [25], zero [31:26]
    input  logic [hdhc_pkg::S_TDATA_W-1:0]    s_tdata,
    // temp_valid [0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // duty_permille [9:0], voltage_cut [10], prewarming [11], zero [15:12]
    output logic [hdhc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hdhc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hdhc_pkg::CFG_DAT_W-1:0]    cfg_data
);
    import hdhc_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   in_reg;
    logic    in_valid_reg;
    result_t out_reg;
    result_t result_next;
    logic    out_valid_reg;
    logic    out_free;
    logic    advance;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_VBAT_CUT:    cfg_reg.vbat_cut_mv     <= cfg_data;
                REG_VBAT_RESUME: cfg_reg.vbat_resume_mv  <= cfg_data;
                REG_VBAT_RICH:   cfg_reg.vbat_rich_mv    <= cfg_data;
                REG_TEMP_OFF:    cfg_reg.temp_off_c10    <= $signed(cfg_data[TEMP_W-1:0]);
                REG_TEMP_WARM:   cfg_reg.temp_warm_c10   <= $signed(cfg_data[TEMP_W-1:0]);
                REG_TEMP_COLD:   cfg_reg.temp_cold_c10   <= $signed(cfg_data[TEMP_W-1:0]);
                REG_TEMP_HYST:   cfg_reg.temp_hyst_c10   <= cfg_data[HYST_W-1:0];
                REG_PREWARM:     cfg_reg.prewarm_seconds <= cfg_data[COUNT_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg.temp_tenths    <= $signed(s_tdata[11:0]);
            in_reg.vbat_mv        <= s_tdata[24:12];
            in_reg.ranging_active <= s_tdata[25];
            in_reg.temp_valid     <= s_tuser;
        end
    end

    hdhc_core u_core (
        .item       (in_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .result     (result_next),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.prewarming, out_reg.voltage_cut,
                       out_reg.duty_permille};

`ifndef SYNTH
    a_cut_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[10] |-> (m_tdata[9:0] == DUTY_OFF) && !m_tdata[11])
        else $error("cut result carries a duty");

    a_prewarm_duty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[11] |-> (m_tdata[9:0] == DUTY_PREWARM))
        else $error("prewarm result with wrong duty");

    a_state_still: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state moved without a tick");

    a_held_tick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_reg))
        else $error("stalled tick lost");

    a_countdown_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result_next.prewarming
        |=> state_reg.prewarm_left == $past(state_reg.prewarm_left) - COUNT_W'(1))
        else $error("prewarm countdown did not step");
`endif

endmodule
